// ----- rtl/i2cee_pkg.sv -----
// i2cee_pkg: shared widths, command and status codes of the eeprom i2c sequencer
// no dependencies; imported by the channel interfaces and the top level
package i2cee_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int WDATA_W  = 64;
    localparam int STATUS_W = 2;
    localparam int DEVADR_W = 7;
    localparam int WAIT_W   = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_TICK  = 2'd0;
    localparam action_t ACT_READ  = 2'd1;
    localparam action_t ACT_WRITE = 2'd2;

    localparam status_t ST_NONE   = 2'd0;
    localparam status_t ST_OK     = 2'd1;
    localparam status_t ST_NACK   = 2'd2;
    localparam status_t ST_REJECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAIT_TICKS = 1'd1;

    localparam logic [DEVADR_W-1:0] DEVADR_RESET = 7'd80;
    localparam logic [WAIT_W-1:0]   WAIT_RESET   = 20'd600;

endpackage

// ----- rtl/i2cee_item_if.sv -----
// i2cee_item_if: input channel carrying one tick or command beat
// depends on i2cee_pkg
interface i2cee_item_if;
    import i2cee_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [BYTE_W-1:0]    mem_address;
    logic [BYTE_W-1:0]    byte_count;
    logic [WDATA_W-1:0]   write_bytes;
    logic                 sda_sample;

    modport source (output valid, action, mem_address, byte_count, write_bytes, sda_sample,
                    input ready);
    modport sink   (input valid, action, mem_address, byte_count, write_bytes, sda_sample,
                    output ready);
endinterface

// ----- rtl/i2cee_result_if.sv -----
// i2cee_result_if: output channel carrying one slot result beat
// depends on i2cee_pkg
interface i2cee_result_if;
    import i2cee_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic [BYTE_W-1:0]    read_byte;
    logic                 read_valid;
    logic                 read_last;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, scl_level, sda_level, busy_res, read_byte, read_valid,
                    read_last, status, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, read_byte, read_valid,
                    read_last, status, output ready);
endinterface

// ----- rtl/i2c_eeprom_master_sequencer.sv -----
// i2c_eeprom_master_sequencer: bus sequencer for serial eeprom random read and page write
// depends on i2cee_pkg, i2cee_item_if, i2cee_result_if
//
// Every input beat is one delay slot of bus timing (or a command). The block answers each beat
// with exactly one result beat giving the open-drain scl/sda levels for that slot, busy, a
// received byte when one completes, and an end status. A read command sends start, device
// write address, memory address, repeated start, device read address, then clocks in
// byte_count bytes (ack on all but the last) and stops. A write command sends start, device
// write address, memory address and up to PAGE_BYTES data bytes, stops, then stays busy for
// write_wait_ticks ticks. A missing ack from the slave ends with stop and status "no ack";
// a zero length ends at once with "ok"; a command while busy, or a write longer than a page,
// is rejected. Throughput is one beat per clock while result.ready is high: the whole
// sequencer state update for a beat is one pass of logic into the state and result
// registers, and the result register lets a new beat enter while the previous result is
// still being taken. Configuration writes go through cfg_we/cfg_index/cfg_data (index 0
// device address, index 1 write wait ticks) and should only be made while idle.
module i2c_eeprom_master_sequencer #(
    parameter int PAGE_BYTES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_data,
    i2cee_item_if.sink                       item,
    i2cee_result_if.source                   result
);
    import i2cee_pkg::*;

    // bus sequencing phases
    typedef enum logic [2:0] {
        PH_IDLE, PH_START, PH_WBIT, PH_WACK, PH_RBIT, PH_RACK, PH_STOP, PH_WAIT
    } phase_t;

    // which byte of the transaction is on the bus
    typedef enum logic [2:0] {
        SG_DEVW, SG_MEM, SG_DEVR, SG_READ, SG_DATA
    } stage_t;

    localparam logic [BYTE_W-1:0] PAGE_LIMIT = BYTE_W'(PAGE_BYTES);

    // configuration
    logic [DEVADR_W-1:0] dev_addr_reg;
    logic [WAIT_W-1:0]   wait_ticks_reg;

    // sequencer state
    phase_t              phase_reg, phase_next;
    stage_t              stage_reg, stage_next;
    logic [1:0]          slot_reg, slot_next;
    logic [3:0]          bit_reg, bit_next;
    logic [BYTE_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]   total_reg, total_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [WDATA_W-1:0]  wbuf_reg, wbuf_next;
    logic [BYTE_W-1:0]   addr_reg, addr_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                is_read_reg, is_read_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_reg, ack_next;
    status_t             end_code_reg, end_code_next;

    // result register
    logic                out_valid_reg;
    logic                busy_reg, busy_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic                rvalid_reg, rvalid_next;
    logic                rlast_reg, rlast_next;
    status_t             status_reg, status_next;

    logic accept;

    // a new beat may enter whenever the result register is empty or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid      = out_valid_reg;
    assign result.scl_level  = scl_reg;
    assign result.sda_level  = sda_reg;
    assign result.busy_res   = busy_reg;
    assign result.read_byte  = rbyte_reg;
    assign result.read_valid = rvalid_reg;
    assign result.read_last  = rlast_reg;
    assign result.status     = status_reg;

    always_comb
    begin
        logic [BYTE_W-1:0] dev_w;
        logic [BYTE_W-1:0] dec_left;
        logic [2:0]        data_idx;
        logic [BYTE_W-1:0] data_b;
        logic [BYTE_W-1:0] shifted;

        dev_w    = {dev_addr_reg, 1'b0};
        dec_left = bytes_left_reg - BYTE_W'(1);
        data_idx = 3'(total_reg - bytes_left_reg);
        data_b   = wbuf_reg[data_idx*BYTE_W +: BYTE_W];
        shifted  = {shift_reg[BYTE_W-2:0], item.sda_sample};

        phase_next      = phase_reg;
        stage_next      = stage_reg;
        slot_next       = slot_reg;
        bit_next        = bit_reg;
        bytes_left_next = bytes_left_reg;
        total_next      = total_reg;
        shift_next      = shift_reg;
        wbuf_next       = wbuf_reg;
        addr_next       = addr_reg;
        wait_next       = wait_reg;
        is_read_next    = is_read_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_next        = ack_reg;
        end_code_next   = end_code_reg;

        busy_next   = 1'b0;
        rbyte_next  = '0;
        rvalid_next = 1'b0;
        rlast_next  = 1'b0;
        status_next = ST_NONE;

        if (item.action == ACT_READ || item.action == ACT_WRITE)
        begin
            if (phase_reg != PH_IDLE)
            begin
                busy_next   = 1'b1;
                status_next = ST_REJECT;
            end
            else if (item.byte_count == '0)
            begin
                status_next = ST_OK;
            end
            else if (item.action == ACT_WRITE && item.byte_count > PAGE_LIMIT)
            begin
                status_next = ST_REJECT;
            end
            else
            begin
                busy_next       = 1'b1;
                is_read_next    = (item.action == ACT_READ);
                addr_next       = item.mem_address;
                bytes_left_next = item.byte_count;
                total_next      = item.byte_count;
                if (item.action == ACT_WRITE)
                begin
                    wbuf_next = item.write_bytes;
                end
                stage_next = SG_DEVW;
                phase_next = PH_START;
                slot_next  = 2'd0;
                bit_next   = 4'd0;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            busy_next = 1'b1;
            case (phase_reg)
                PH_START:
                begin
                    case (slot_reg)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                    if (slot_reg == 2'd3)
                    begin
                        shift_next = (stage_reg == SG_DEVR) ? (dev_w | BYTE_W'(1)) : dev_w;
                        bit_next   = 4'd0;
                        slot_next  = 2'd0;
                        phase_next = PH_WBIT;
                    end
                    else
                    begin
                        slot_next = slot_reg + 2'd1;
                    end
                end
                PH_WBIT:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        sda_next  = shift_reg[3'd7 - bit_reg[2:0]];
                        slot_next = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_next  = 1'b1;
                        slot_next = 2'd2;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        slot_next = 2'd0;
                        bit_next  = bit_reg + 4'd1;
                        if (bit_reg + 4'd1 >= 4'd8)
                        begin
                            phase_next = PH_WACK;
                        end
                    end
                end
                PH_WACK:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        sda_next  = 1'b1;
                        slot_next = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_next  = 1'b1;
                        ack_next  = !item.sda_sample;
                        slot_next = 2'd2;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        slot_next = 2'd0;
                        if (!ack_reg)
                        begin
                            end_code_next = ST_NACK;
                            phase_next    = PH_STOP;
                        end
                        else
                        begin
                            case (stage_reg)
                                SG_DEVW:
                                begin
                                    stage_next = SG_MEM;
                                    shift_next = addr_reg;
                                    bit_next   = 4'd0;
                                    phase_next = PH_WBIT;
                                end
                                SG_MEM:
                                begin
                                    if (is_read_reg)
                                    begin
                                        stage_next = SG_DEVR;
                                        phase_next = PH_START;
                                    end
                                    else
                                    begin
                                        stage_next = SG_DATA;
                                        shift_next = data_b;
                                        bit_next   = 4'd0;
                                        phase_next = PH_WBIT;
                                    end
                                end
                                SG_DEVR:
                                begin
                                    stage_next = SG_READ;
                                    phase_next = PH_RBIT;
                                    bit_next   = 4'd0;
                                    shift_next = '0;
                                end
                                default:
                                begin
                                    // data byte acked: next byte or stop
                                    bytes_left_next = dec_left;
                                    if (dec_left == '0)
                                    begin
                                        end_code_next = ST_OK;
                                        phase_next    = PH_STOP;
                                    end
                                    else
                                    begin
                                        shift_next = wbuf_reg[3'(total_reg - dec_left)*BYTE_W
                                                              +: BYTE_W];
                                        bit_next   = 4'd0;
                                        phase_next = PH_WBIT;
                                    end
                                end
                            endcase
                        end
                    end
                end
                PH_RBIT:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        sda_next  = 1'b1;
                        scl_next  = 1'b0;
                        slot_next = 2'd1;
                    end
                    else
                    begin
                        scl_next   = 1'b1;
                        shift_next = shifted;
                        bit_next   = bit_reg + 4'd1;
                        slot_next  = 2'd0;
                        if (bit_reg + 4'd1 >= 4'd8)
                        begin
                            rvalid_next = 1'b1;
                            rbyte_next  = shifted;
                            rlast_next  = (bytes_left_reg == BYTE_W'(1));
                            phase_next  = PH_RACK;
                        end
                    end
                end
                PH_RACK:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        scl_next  = 1'b0;
                        // nack the final byte, ack the others
                        sda_next  = (bytes_left_reg == BYTE_W'(1));
                        slot_next = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_next  = 1'b1;
                        slot_next = 2'd2;
                    end
                    else
                    begin
                        scl_next        = 1'b0;
                        slot_next       = 2'd0;
                        bytes_left_next = dec_left;
                        if (dec_left == '0)
                        begin
                            end_code_next = ST_OK;
                            phase_next    = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_RBIT;
                            bit_next   = 4'd0;
                            shift_next = '0;
                        end
                    end
                end
                PH_STOP:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        sda_next  = 1'b0;
                        slot_next = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_next  = 1'b1;
                        slot_next = 2'd2;
                    end
                    else
                    begin
                        sda_next  = 1'b1;
                        slot_next = 2'd0;
                        if (end_code_reg == ST_OK && !is_read_reg && wait_ticks_reg != '0)
                        begin
                            wait_next  = wait_ticks_reg;
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            status_next = end_code_reg;
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                PH_WAIT:
                begin
                    scl_next  = 1'b1;
                    sda_next  = 1'b1;
                    wait_next = wait_reg - WAIT_W'(1);
                    if (wait_reg == WAIT_W'(1))
                    begin
                        status_next = ST_OK;
                        phase_next  = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= DEVADR_RESET;
            wait_ticks_reg <= WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:   dev_addr_reg   <= cfg_data[DEVADR_W-1:0];
                CFG_WRITE_WAIT_TICKS: wait_ticks_reg <= cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state, updated once per accepted beat, and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            stage_reg      <= SG_DEVW;
            slot_reg       <= 2'd0;
            bit_reg        <= 4'd0;
            bytes_left_reg <= '0;
            total_reg      <= '0;
            shift_reg      <= '0;
            addr_reg       <= '0;
            wait_reg       <= '0;
            is_read_reg    <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_reg        <= 1'b0;
            end_code_reg   <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                stage_reg      <= stage_next;
                slot_reg       <= slot_next;
                bit_reg        <= bit_next;
                bytes_left_reg <= bytes_left_next;
                total_reg      <= total_next;
                shift_reg      <= shift_next;
                addr_reg       <= addr_next;
                wait_reg       <= wait_next;
                is_read_reg    <= is_read_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                ack_reg        <= ack_next;
                end_code_reg   <= end_code_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: write buffer and the rest of the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wbuf_reg   <= wbuf_next;
            busy_reg   <= busy_next;
            rbyte_reg  <= rbyte_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- tb/tb_i2c_eeprom_master_sequencer.sv -----
// tb_i2c_eeprom_master_sequencer: self-checking bench for the eeprom i2c bus sequencer
// holds a slot scoreboard class and the top module that drives and watches the dut
// depends on i2cee_pkg, i2cee_item_if, i2cee_result_if and the rtl top level
import i2cee_pkg::*;

typedef struct packed {
    action_t              action;
    logic [BYTE_W-1:0]    mem_address;
    logic [BYTE_W-1:0]    byte_count;
    logic [WDATA_W-1:0]   write_bytes;
    logic                 sda_sample;
} bus_beat_t;

typedef struct packed {
    logic                 scl;
    logic                 sda;
    logic                 busy;
    logic [BYTE_W-1:0]    read_byte;
    logic                 read_valid;
    logic                 read_last;
    status_t              status;
} slot_result_t;

class eeprom_bus_scoreboard;
    typedef enum logic [2:0] {
        B_IDLE, B_START, B_SEND, B_SEND_ACK, B_RECV, B_RECV_ACK, B_STOP, B_WAIT
    } bus_phase_e;
    typedef enum logic [2:0] {
        SEG_DEV_WR, SEG_MEM, SEG_DEV_RD, SEG_READ, SEG_DATA
    } segment_e;

    int                   page_bytes;
    logic [DEVADR_W-1:0]  dev_addr;
    logic [WAIT_W-1:0]    wait_ticks;

    bus_phase_e           phase;
    segment_e             segment;
    logic [1:0]           slot;
    logic [3:0]           bit_cnt;
    logic [7:0]           bytes_left;
    logic [7:0]           total;
    logic [7:0]           shifter;
    logic [63:0]          wbuf;
    logic [7:0]           mem_latch;
    logic [WAIT_W-1:0]    wait_cnt;
    logic                 reading;
    logic                 scl;
    logic                 sda;
    logic                 acked;
    status_t              end_status;

    slot_result_t         pending_slots[$];
    int                   failures;
    int                   slots_checked;
    int                   bytes_received;
    int                   done_count;
    int                   nack_count;
    int                   reject_count;

    function new(int page);
        page_bytes = page;
        dev_addr   = DEVADR_RESET;
        wait_ticks = WAIT_RESET;
        phase      = B_IDLE;
        segment    = SEG_DEV_WR;
        slot       = '0;
        bit_cnt    = '0;
        bytes_left = '0;
        total      = '0;
        shifter    = '0;
        wbuf       = '0;
        mem_latch  = '0;
        wait_cnt   = '0;
        reading    = 1'b0;
        scl        = 1'b1;
        sda        = 1'b1;
        acked      = 1'b0;
        end_status = ST_OK;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_DEVICE_ADDRESS)
            dev_addr = val[DEVADR_W-1:0];
        else
            wait_ticks = val[WAIT_W-1:0];
    endfunction

    function bit idle();
        return phase == B_IDLE;
    endfunction

    // the next tick is the one where the slave ack is sampled
    function bit ack_slot_due();
        return phase == B_SEND_ACK && slot == 2'd1;
    endfunction

    function void load_byte(logic [7:0] b);
        shifter = b;
        bit_cnt = '0;
        slot    = '0;
        phase   = B_SEND;
    endfunction

    function void begin_stop(status_t code);
        end_status = code;
        phase      = B_STOP;
        slot       = '0;
    endfunction

    function logic [7:0] next_data_byte();
        logic [7:0] idx;
        idx = total - bytes_left;
        return wbuf[idx[2:0]*8 +: 8];
    endfunction

    function slot_result_t advance_bus(bus_beat_t b);
        slot_result_t r;
        r = '0;
        if (b.action == ACT_READ || b.action == ACT_WRITE) begin
            if (phase != B_IDLE) begin
                r.busy   = 1'b1;
                r.status = ST_REJECT;
            end
            else if (b.byte_count == 0) begin
                r.status = ST_OK;
            end
            else if (b.action == ACT_WRITE && b.byte_count > page_bytes) begin
                r.status = ST_REJECT;
            end
            else begin
                r.busy     = 1'b1;
                reading    = (b.action == ACT_READ);
                mem_latch  = b.mem_address;
                bytes_left = b.byte_count;
                total      = b.byte_count;
                if (b.action == ACT_WRITE)
                    wbuf = b.write_bytes;
                segment = SEG_DEV_WR;
                phase   = B_START;
                slot    = '0;
                bit_cnt = '0;
            end
        end
        else if (phase != B_IDLE) begin
            r.busy = 1'b1;
            case (phase)
                B_START: begin
                    case (slot)
                        2'd0: sda = 1'b1;
                        2'd1: scl = 1'b1;
                        2'd2: sda = 1'b0;
                        default: scl = 1'b0;
                    endcase
                    if (slot == 2'd3)
                        load_byte({dev_addr, segment == SEG_DEV_RD});
                    else
                        slot = slot + 2'd1;
                end
                B_SEND: begin
                    if (slot == 2'd0) begin
                        sda  = shifter[3'd7 - bit_cnt[2:0]];
                        slot = 2'd1;
                    end
                    else if (slot == 2'd1) begin
                        scl  = 1'b1;
                        slot = 2'd2;
                    end
                    else begin
                        scl     = 1'b0;
                        slot    = 2'd0;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8)
                            phase = B_SEND_ACK;
                    end
                end
                B_SEND_ACK: begin
                    if (slot == 2'd0) begin
                        sda  = 1'b1;
                        slot = 2'd1;
                    end
                    else if (slot == 2'd1) begin
                        scl   = 1'b1;
                        acked = (b.sda_sample == 1'b0);
                        slot  = 2'd2;
                    end
                    else begin
                        scl = 1'b0;
                        if (!acked) begin
                            begin_stop(ST_NACK);
                        end
                        else if (segment == SEG_DEV_WR) begin
                            segment = SEG_MEM;
                            load_byte(mem_latch);
                        end
                        else if (segment == SEG_MEM) begin
                            if (reading) begin
                                segment = SEG_DEV_RD;
                                phase   = B_START;
                                slot    = '0;
                            end
                            else begin
                                segment = SEG_DATA;
                                load_byte(next_data_byte());
                            end
                        end
                        else if (segment == SEG_DEV_RD) begin
                            segment = SEG_READ;
                            phase   = B_RECV;
                            slot    = '0;
                            bit_cnt = '0;
                            shifter = '0;
                        end
                        else begin
                            bytes_left = bytes_left - 8'd1;
                            if (bytes_left == 0)
                                begin_stop(ST_OK);
                            else
                                load_byte(next_data_byte());
                        end
                    end
                end
                B_RECV: begin
                    if (slot == 2'd0) begin
                        sda  = 1'b1;
                        scl  = 1'b0;
                        slot = 2'd1;
                    end
                    else begin
                        scl     = 1'b1;
                        shifter = {shifter[6:0], b.sda_sample};
                        bit_cnt = bit_cnt + 4'd1;
                        slot    = 2'd0;
                        if (bit_cnt >= 4'd8) begin
                            r.read_valid = 1'b1;
                            r.read_byte  = shifter;
                            r.read_last  = (bytes_left == 8'd1);
                            phase        = B_RECV_ACK;
                        end
                    end
                end
                B_RECV_ACK: begin
                    if (slot == 2'd0) begin
                        scl  = 1'b0;
                        sda  = (bytes_left == 8'd1);
                        slot = 2'd1;
                    end
                    else if (slot == 2'd1) begin
                        scl  = 1'b1;
                        slot = 2'd2;
                    end
                    else begin
                        scl        = 1'b0;
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 0) begin
                            begin_stop(ST_OK);
                        end
                        else begin
                            phase   = B_RECV;
                            slot    = '0;
                            bit_cnt = '0;
                            shifter = '0;
                        end
                    end
                end
                B_STOP: begin
                    if (slot == 2'd0) begin
                        sda  = 1'b0;
                        slot = 2'd1;
                    end
                    else if (slot == 2'd1) begin
                        scl  = 1'b1;
                        slot = 2'd2;
                    end
                    else begin
                        sda  = 1'b1;
                        slot = 2'd0;
                        if (end_status == ST_OK && !reading && wait_ticks != 0) begin
                            wait_cnt = wait_ticks;
                            phase    = B_WAIT;
                        end
                        else begin
                            r.status = end_status;
                            phase    = B_IDLE;
                        end
                    end
                end
                B_WAIT: begin
                    scl      = 1'b1;
                    sda      = 1'b1;
                    wait_cnt = wait_cnt - 1'b1;
                    if (wait_cnt == 0) begin
                        r.status = ST_OK;
                        phase    = B_IDLE;
                    end
                end
                default: begin
                    phase = B_IDLE;
                    scl   = 1'b1;
                    sda   = 1'b1;
                end
            endcase
        end
        r.scl = scl;
        r.sda = sda;
        if (r.read_valid)
            bytes_received++;
        case (r.status)
            ST_OK:     done_count++;
            ST_NACK:   nack_count++;
            ST_REJECT: reject_count++;
            default: ;
        endcase
        return r;
    endfunction

    function void note_item(bus_beat_t b);
        pending_slots.push_back(advance_bus(b));
    endfunction

    function void fail(string msg);
        failures++;
        if (failures <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(slot_result_t got);
        slot_result_t exp;
        bit bad;
        slots_checked++;
        if (pending_slots.size() == 0) begin
            fail("result beat arrived with no slot pending");
            return;
        end
        exp = pending_slots.pop_front();
        bad = (got.scl !== exp.scl) || (got.sda !== exp.sda) || (got.busy !== exp.busy)
              || (got.read_byte !== exp.read_byte) || (got.read_valid !== exp.read_valid)
              || (got.read_last !== exp.read_last) || (got.status !== exp.status);
        if (bad)
            fail($sformatf({"slot %0d: exp scl=%b sda=%b busy=%b byte=%h rv=%b rl=%b st=%0d",
                            " got scl=%b sda=%b busy=%b byte=%h rv=%b rl=%b st=%0d"},
                           slots_checked, exp.scl, exp.sda, exp.busy, exp.read_byte,
                           exp.read_valid, exp.read_last, exp.status, got.scl, got.sda,
                           got.busy, got.read_byte, got.read_valid, got.read_last,
                           got.status));
    endfunction
endclass

module tb_i2c_eeprom_master_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES = 8;
    localparam int NO_NACK    = -1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cee_item_if   item_ch();
    i2cee_result_if result_ch();

    eeprom_bus_scoreboard slot_board = new(PAGE_BYTES);

    int beats_sent    = 0;
    // while set, neither side inserts idle cycles
    bit quiet_stretch = 1'b0;

    i2c_eeprom_master_sequencer #(
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        result_ch.ready <= quiet_stretch || ($urandom_range(99) >= 6);
    end

    // result monitor: every accepted result beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            slot_board.check_result({result_ch.scl_level, result_ch.sda_level,
                                     result_ch.busy_res, result_ch.read_byte,
                                     result_ch.read_valid, result_ch.read_last,
                                     result_ch.status});
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // offers one input beat from a falling edge and returns on the falling edge after it
    // was taken; valid stays high across back-to-back beats
    task automatic send_beat(input bus_beat_t b);
        if (!quiet_stretch && $urandom_range(99) < 6)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.action      <= b.action;
        item_ch.mem_address <= b.mem_address;
        item_ch.byte_count  <= b.byte_count;
        item_ch.write_bytes <= b.write_bytes;
        item_ch.sda_sample  <= b.sda_sample;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        slot_board.note_item(b);
        beats_sent++;
        @(negedge clk);
    endtask

    // a delay slot with junk in the fields the block ignores on a tick
    function automatic bus_beat_t random_tick();
        bus_beat_t b;
        b.action      = ACT_TICK;
        b.mem_address = 8'($urandom_range(255));
        b.byte_count  = 8'($urandom_range(255));
        b.write_bytes = {$urandom, $urandom};
        b.sda_sample  = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic bus_beat_t command_beat(input action_t act, input logic [7:0] mem,
                                               input logic [7:0] cnt, input logic [63:0] data);
        bus_beat_t b;
        b = random_tick();
        b.action      = act;
        b.mem_address = mem;
        b.byte_count  = cnt;
        b.write_bytes = data;
        return b;
    endfunction

    // issues a command and ticks the bus until the sequencer is idle again
    // nack_at: index of the slave ack slot that is answered with a nack (NO_NACK for none)
    // nack_pct: chance of a stray nack on any ack slot
    // poke_pct: chance of throwing a command at the busy block instead of a tick
    task automatic run_transaction(input action_t act, input logic [7:0] mem,
                                   input logic [7:0] cnt, input logic [63:0] data,
                                   input int nack_at, input int nack_pct, input int poke_pct);
        bus_beat_t b;
        int        acks;
        acks = 0;
        send_beat(command_beat(act, mem, cnt, data));
        while (!slot_board.idle())
        begin
            if ($urandom_range(99) < poke_pct)
            begin
                b = command_beat($urandom_range(1) ? ACT_READ : ACT_WRITE,
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 {$urandom, $urandom});
            end
            else
            begin
                b = random_tick();
                // the slave side: ack by pulling sda low on the sampled slot
                if (slot_board.ack_slot_due())
                begin
                    b.sda_sample = (acks == nack_at) || ($urandom_range(99) < nack_pct);
                    acks++;
                end
            end
            send_beat(b);
        end
    endtask

    // register writes only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        slot_board.set_register(idx, val);
    endtask

    // stop offering beats and let every predicted result come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (slot_board.pending_slots.size() != 0) @(negedge clk);
        // settling margin before the next step
        repeat (4) @(negedge clk);
    endtask

    // mostly well-formed transactions with random content, some noise around them
    task automatic random_traffic(input int beats, input bit reads_only, input int calm_beats);
        int stop_at;
        int calm_until;
        int pick;
        stop_at    = beats_sent + beats;
        calm_until = beats_sent + calm_beats;
        while (beats_sent < stop_at)
        begin
            quiet_stretch = (beats_sent < calm_until);
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // idle ticks between transactions
                repeat ($urandom_range(1, 4)) send_beat(random_tick());
            end
            else if (pick < 14)
            begin
                // commands that finish at once: zero length or an over-long write
                case ($urandom_range(2))
                    0: send_beat(command_beat(ACT_READ, 8'($urandom_range(255)), 8'd0,
                                              {$urandom, $urandom}));
                    1: send_beat(command_beat(ACT_WRITE, 8'($urandom_range(255)), 8'd0,
                                              {$urandom, $urandom}));
                    default: send_beat(command_beat(ACT_WRITE, 8'($urandom_range(255)),
                                                    8'($urandom_range(PAGE_BYTES + 1, 255)),
                                                    {$urandom, $urandom}));
                endcase
            end
            else if (reads_only || pick < 57)
            begin
                run_transaction(ACT_READ, 8'($urandom_range(255)),
                                ($urandom_range(9) == 0) ? 8'($urandom_range(5, 16))
                                                         : 8'($urandom_range(1, 4)),
                                {$urandom, $urandom}, NO_NACK, 3, 2);
            end
            else
            begin
                run_transaction(ACT_WRITE, 8'($urandom_range(255)),
                                8'($urandom_range(1, PAGE_BYTES)),
                                {$urandom, $urandom}, NO_NACK, 3, 2);
            end
        end
        quiet_stretch = 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_DEVICE_ADDRESS;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_TICK;
        item_ch.mem_address   = '0;
        item_ch.byte_count    = '0;
        item_ch.write_bytes   = '0;
        item_ch.sda_sample    = 1'b1;
        result_ch.ready       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at reset settings (address 80, wait 600)
        send_beat(random_tick());
        // zero length, both directions
        send_beat(command_beat(ACT_READ, 8'h10, 8'd0, '0));
        send_beat(command_beat(ACT_WRITE, 8'h10, 8'd0, '1));
        // writes longer than a page are turned away
        send_beat(command_beat(ACT_WRITE, 8'h20, 8'd9, '1));
        send_beat(command_beat(ACT_WRITE, 8'h20, 8'd255, '0));
        // clean single-byte read from the top address
        run_transaction(ACT_READ, 8'hFF, 8'd1, '0, NO_NACK, 0, 0);
        // one byte of ones to address zero, then the full reset write wait
        run_transaction(ACT_WRITE, 8'h00, 8'd1, '1, NO_NACK, 0, 0);
        drain();

        // lowest device address, no write wait
        write_reg(CFG_DEVICE_ADDRESS, 20'd0);
        write_reg(CFG_WRITE_WAIT_TICKS, 20'd0);
        // nack on the device address, the memory address, the read address after the
        // repeated start, the first data byte and the last data byte of a write
        run_transaction(ACT_READ, 8'h01, 8'd2, '0, 0, 0, 0);
        run_transaction(ACT_WRITE, 8'h02, 8'd3, 64'h0123_4567_89AB_CDEF, 1, 0, 0);
        run_transaction(ACT_READ, 8'h03, 8'd2, '0, 2, 0, 0);
        run_transaction(ACT_WRITE, 8'h04, 8'd4, 64'hFEDC_BA98_7654_3210, 2, 0, 0);
        run_transaction(ACT_WRITE, 8'hAA, 8'd2, 64'h5A5A_A5A5_0F0F_F0F0, 3, 0, 0);
        // commands thrown at a busy block get rejected without moving the bus
        run_transaction(ACT_READ, 8'h7E, 8'd1, '0, NO_NACK, 0, 40);
        // starts with a stretch with no idling
        random_traffic(220, 1'b0, 180);
        drain();

        // highest device address, one-tick write wait
        write_reg(CFG_DEVICE_ADDRESS, 20'd127);
        write_reg(CFG_WRITE_WAIT_TICKS, 20'd1);
        random_traffic(150, 1'b0, 0);
        drain();

        // longest write wait; only traffic that never reaches the wait
        write_reg(CFG_DEVICE_ADDRESS, 20'($urandom_range(127)));
        write_reg(CFG_WRITE_WAIT_TICKS, 20'hFFFFF);
        run_transaction(ACT_WRITE, 8'($urandom_range(255)), 8'd5, {$urandom, $urandom},
                        0, 0, 0);
        random_traffic(60, 1'b1, 0);
        drain();

        $display("run covered %0d input beats and %0d result beats over four register settings",
                 beats_sent, slot_board.slots_checked);
        $display("%0d bytes read, %0d ok endings, %0d nacks, %0d rejected commands",
                 slot_board.bytes_received, slot_board.done_count, slot_board.nack_count,
                 slot_board.reject_count);
        if (slot_board.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
